// ===== rtl/core/sha1md_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// sha1md_pkg
// Shared types, constants and round functions of the SHA-1 digest engine.
// ---------------------------------------------------------------------------
package sha1md_pkg;

  localparam int BLOCK_WORDS  = 16;
  localparam int ROUNDS       = 80;
  localparam int DIGEST_WORDS = 5;
  localparam int CMDQ_DEPTH   = 4;
  localparam int CMDQ_AW      = $clog2(CMDQ_DEPTH);
  localparam int FILL_W       = $clog2(BLOCK_WORDS);
  localparam int RND_W        = $clog2(ROUNDS);
  localparam int BITS_W       = 6;

  localparam logic [31:0] INIT_VALUE [DIGEST_WORDS] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [31:0] PAD_ONLY = 32'h80000000;
  localparam logic [7:0]  PAD_BYTE = 8'h80;

  // Byte counts on a last word
  localparam logic [2:0] CNT_EMPTY = 3'd0;
  localparam logic [2:0] CNT_ONE   = 3'd1;
  localparam logic [2:0] CNT_TWO   = 3'd2;
  localparam logic [2:0] CNT_THREE = 3'd3;
  localparam logic [2:0] CNT_FULL  = 3'd4;

  // Command passed from front to back
  typedef struct packed {
    logic              is_pad;  // word closes the message
    logic [31:0]       word;
    logic [BITS_W-1:0] bits;    // message bits this word adds
  } cmd_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
    rotl = (x << n) | (x >> (32 - n));
  endfunction

  // Word holding the message tail and the 0x80 marker, count 0..3
  function automatic logic [31:0] pad_word(input logic [31:0] w, input logic [2:0] cnt);
    unique case (cnt)
      CNT_ONE:   pad_word = {w[31:24], PAD_BYTE, 16'h0000};
      CNT_TWO:   pad_word = {w[31:16], PAD_BYTE, 8'h00};
      CNT_THREE: pad_word = {w[31:8], PAD_BYTE};
      default:   pad_word = PAD_ONLY;
    endcase
  endfunction

  function automatic logic [31:0] round_k(input logic [RND_W-1:0] r);
    priority if (r < RND_W'(20)) round_k = K0;
    else if (r < RND_W'(40))     round_k = K1;
    else if (r < RND_W'(60))     round_k = K2;
    else                         round_k = K3;
  endfunction

  function automatic logic [31:0] round_f(input logic [RND_W-1:0] r,
                                          input logic [31:0] b,
                                          input logic [31:0] c,
                                          input logic [31:0] d);
    priority if (r < RND_W'(20)) round_f = d ^ (b & (c ^ d));
    else if (r < RND_W'(40))     round_f = b ^ c ^ d;
    else if (r < RND_W'(60))     round_f = (b & c) | (d & (b | c));
    else                         round_f = b ^ c ^ d;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/sha1md_front.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// sha1md_front
// Accepts message words and turns them into data and pad commands.
// A full last word yields a data command followed by a pad command.
// ---------------------------------------------------------------------------
module sha1md_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  output logic                   full,
  input  wire logic [31:0]       data_word,
  input  wire logic [2:0]        byte_count,
  input  wire logic              last,
  output logic                   enq,
  output sha1md_pkg::cmd_t       enq_cmd,
  input  wire logic              q_full
);

  logic             pend_valid;
  sha1md_pkg::cmd_t pend_cmd;
  logic             accept;
  logic [2:0]       cnt;

  assign full   = pend_valid | q_full;
  assign accept = push & ~full;
  assign cnt    = (byte_count > sha1md_pkg::CNT_FULL) ? sha1md_pkg::CNT_FULL : byte_count;

  // classify the accepted item, or drain the pending pad command
  always_comb begin
    enq     = 1'b0;
    enq_cmd = '0;
    if (pend_valid) begin
      enq     = ~q_full;
      enq_cmd = pend_cmd;
    end else if (accept) begin
      enq = 1'b1;
      if (!last || cnt == sha1md_pkg::CNT_FULL) begin
        enq_cmd.is_pad = 1'b0;
        enq_cmd.word   = data_word;
        enq_cmd.bits   = sha1md_pkg::BITS_W'(32);
      end else begin
        enq_cmd.is_pad = 1'b1;
        enq_cmd.word   = sha1md_pkg::pad_word(data_word, cnt);
        enq_cmd.bits   = sha1md_pkg::BITS_W'({cnt, 3'b000});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (pend_valid) begin
      if (!q_full) pend_valid <= 1'b0;
    end else if (accept && last && cnt == sha1md_pkg::CNT_FULL) begin
      pend_valid <= 1'b1;
    end
  end

  // pad command that follows a full last word
  always_ff @(posedge clk) begin
    if (accept) begin
      pend_cmd.is_pad <= 1'b1;
      pend_cmd.word   <= sha1md_pkg::PAD_ONLY;
      pend_cmd.bits   <= '0;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/sha1md_fifo.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// sha1md_fifo
// Short command queue between the front and the compression back end.
// ---------------------------------------------------------------------------
module sha1md_fifo (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr,
  input  wire sha1md_pkg::cmd_t wr_cmd,
  output logic                  q_full,
  input  wire logic             rd,
  output sha1md_pkg::cmd_t      rd_cmd,
  output logic                  q_empty
);

  sha1md_pkg::cmd_t                  slots [sha1md_pkg::CMDQ_DEPTH];
  logic [sha1md_pkg::CMDQ_AW-1:0]    wr_ptr;
  logic [sha1md_pkg::CMDQ_AW-1:0]    rd_ptr;
  logic [sha1md_pkg::CMDQ_AW:0]      count;
  logic                              do_wr;
  logic                              do_rd;

  assign q_full  = (count == (sha1md_pkg::CMDQ_AW+1)'(sha1md_pkg::CMDQ_DEPTH));
  assign q_empty = (count == '0);
  assign do_wr   = wr & ~q_full;
  assign do_rd   = rd & ~q_empty;
  assign rd_cmd  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= wr_ptr + 1'b1;
      if (do_rd) rd_ptr <= rd_ptr + 1'b1;
      if (do_wr && !do_rd) count <= count + 1'b1;
      else if (do_rd && !do_wr) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) slots[wr_ptr] <= wr_cmd;
  end

endmodule
`default_nettype wire

// ===== rtl/core/sha1md_core.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// sha1md_core
// Block buffer, padding sequencer, one-round-per-cycle compression and
// the digest output buffer.
// ---------------------------------------------------------------------------
module sha1md_core (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             q_empty,
  input  wire sha1md_pkg::cmd_t cmd,
  output logic                  cmd_pop,
  output logic                  empty,
  input  wire logic             pop,
  output logic [31:0]           digest_word,
  output logic [2:0]            word_number,
  output logic                  final_word
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ZERO  = 3'd1;
  localparam logic [2:0] ST_LENLO = 3'd2;
  localparam logic [2:0] ST_ROUND = 3'd3;
  localparam logic [2:0] ST_ADD   = 3'd4;

  localparam logic [sha1md_pkg::FILL_W-1:0] FILL_LAST =
    sha1md_pkg::FILL_W'(sha1md_pkg::BLOCK_WORDS - 1);
  localparam logic [sha1md_pkg::FILL_W-1:0] FILL_LEN_HI =
    sha1md_pkg::FILL_W'(sha1md_pkg::BLOCK_WORDS - 2);
  localparam logic [sha1md_pkg::RND_W-1:0] RND_LAST =
    sha1md_pkg::RND_W'(sha1md_pkg::ROUNDS - 1);
  localparam logic [2:0] IDX_LAST = 3'(sha1md_pkg::DIGEST_WORDS - 1);

  logic [2:0]                       state;
  logic [sha1md_pkg::FILL_W-1:0]    fill;
  logic [63:0]                      bit_len;
  logic                             padding;
  logic                             finishing;
  logic [sha1md_pkg::RND_W-1:0]     rnd;
  logic [31:0]                      cv   [sha1md_pkg::DIGEST_WORDS];
  logic [31:0]                      wbuf [sha1md_pkg::BLOCK_WORDS];
  logic [31:0]                      wa, wb, wc, wd, we;
  logic [31:0]                      bank [sha1md_pkg::DIGEST_WORDS];
  logic [31:0]                      sums [sha1md_pkg::DIGEST_WORDS];
  logic                             out_valid;
  logic [2:0]                       out_idx;

  logic        shift_en;
  logic [31:0] shift_in;
  logic [31:0] sched;
  logic [31:0] temp;
  logic        start_comp;
  logic        out_load;
  logic        out_take;

  assign cmd_pop  = (state == ST_IDLE) & ~q_empty;
  assign sched    = sha1md_pkg::rotl(wbuf[13] ^ wbuf[8] ^ wbuf[2] ^ wbuf[0], 1);
  assign temp     = sha1md_pkg::rotl(wa, 5) + sha1md_pkg::round_f(rnd, wb, wc, wd)
                    + we + wbuf[0] + sha1md_pkg::round_k(rnd);
  assign out_load = (state == ST_ADD) & finishing & ~out_valid;
  assign out_take = pop & out_valid;

  assign sums[0] = cv[0] + wa;
  assign sums[1] = cv[1] + wb;
  assign sums[2] = cv[2] + wc;
  assign sums[3] = cv[3] + wd;
  assign sums[4] = cv[4] + we;

  // word entering the block window this cycle
  always_comb begin
    shift_en = 1'b0;
    shift_in = '0;
    unique case (state)
      ST_IDLE: begin
        shift_en = cmd_pop;
        shift_in = cmd.word;
      end
      ST_ZERO: begin
        shift_en = 1'b1;
        shift_in = (fill == FILL_LEN_HI) ? bit_len[63:32] : 32'h0;
      end
      ST_LENLO: begin
        shift_en = 1'b1;
        shift_in = bit_len[31:0];
      end
      ST_ROUND: begin
        shift_en = 1'b1;
        shift_in = sched;
      end
      default: begin
        shift_en = 1'b0;
        shift_in = '0;
      end
    endcase
  end

  assign start_comp = shift_en & (state != ST_ROUND) & (fill == FILL_LAST);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      fill      <= '0;
      bit_len   <= '0;
      padding   <= 1'b0;
      finishing <= 1'b0;
      rnd       <= '0;
      cv        <= sha1md_pkg::INIT_VALUE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (cmd_pop) begin
            fill    <= fill + 1'b1;
            bit_len <= bit_len + {{(64-sha1md_pkg::BITS_W){1'b0}}, cmd.bits};
            if (cmd.is_pad) padding <= 1'b1;
            if (fill == FILL_LAST) begin
              state <= ST_ROUND;
              rnd   <= '0;
            end else if (cmd.is_pad) begin
              state <= ST_ZERO;
            end
          end
        end
        ST_ZERO: begin
          fill <= fill + 1'b1;
          if (fill == FILL_LEN_HI) begin
            state <= ST_LENLO;
          end else if (fill == FILL_LAST) begin
            state <= ST_ROUND;
            rnd   <= '0;
          end
        end
        ST_LENLO: begin
          fill      <= fill + 1'b1;
          finishing <= 1'b1;
          state     <= ST_ROUND;
          rnd       <= '0;
        end
        ST_ROUND: begin
          rnd <= rnd + 1'b1;
          if (rnd == RND_LAST) state <= ST_ADD;
        end
        ST_ADD: begin
          if (finishing) begin
            if (!out_valid) begin
              cv        <= sha1md_pkg::INIT_VALUE;
              bit_len   <= '0;
              fill      <= '0;
              padding   <= 1'b0;
              finishing <= 1'b0;
              state     <= ST_IDLE;
            end
          end else begin
            cv    <= sums;
            state <= padding ? ST_ZERO : ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // block window and working variables
  always_ff @(posedge clk) begin
    if (shift_en) begin
      for (int i = 0; i < sha1md_pkg::BLOCK_WORDS - 1; i++) wbuf[i] <= wbuf[i+1];
      wbuf[sha1md_pkg::BLOCK_WORDS-1] <= shift_in;
    end
    if (start_comp) begin
      wa <= cv[0];
      wb <= cv[1];
      wc <= cv[2];
      wd <= cv[3];
      we <= cv[4];
    end else if (state == ST_ROUND) begin
      wa <= temp;
      wb <= wa;
      wc <= sha1md_pkg::rotl(wb, 30);
      wd <= wc;
      we <= wd;
    end
  end

  // digest output buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      out_idx   <= '0;
    end else if (out_load) begin
      out_valid <= 1'b1;
      out_idx   <= '0;
    end else if (out_take) begin
      out_idx <= out_idx + 1'b1;
      if (out_idx == IDX_LAST) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      bank <= sums;
    end else if (out_take) begin
      for (int i = 0; i < sha1md_pkg::DIGEST_WORDS - 1; i++) bank[i] <= bank[i+1];
    end
  end

  assign empty       = ~out_valid;
  assign digest_word = bank[0];
  assign word_number = out_idx;
  assign final_word  = (out_idx == IDX_LAST);

endmodule
`default_nettype wire

// ===== rtl/core/sha1_message_digest_top.sv =====
`default_nettype none
// Flow: a data word passes through the front, the command queue and the block
// window; each full block is compressed in 80 rounds by one shared round unit, then the add.
// A last word is padded with zero and length words and takes one or two compressions
// before the first digest word; digest words then leave one per cycle while pop is held.
// No command leaves the queue while a block is compressed; the front accepts until full.
// Reset: synchronous; clears queues and length, loads the initial chaining values.
// ---------------------------------------------------------------------------
// sha1_message_digest_top
// SHA-1 engine: front classifier, command queue and compression back end.
// ---------------------------------------------------------------------------
module sha1_message_digest_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [31:0] data_word,
  input  wire logic [2:0]  byte_count,
  input  wire logic        last,
  output logic             empty,
  input  wire logic        pop,
  output logic [31:0]      digest_word,
  output logic [2:0]       word_number,
  output logic             final_word
);

  logic             enq;
  sha1md_pkg::cmd_t enq_cmd;
  logic             q_full;
  logic             q_empty;
  logic             cmd_pop;
  sha1md_pkg::cmd_t cmd;

  sha1md_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .data_word  (data_word),
    .byte_count (byte_count),
    .last       (last),
    .enq        (enq),
    .enq_cmd    (enq_cmd),
    .q_full     (q_full)
  );

  sha1md_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr      (enq),
    .wr_cmd  (enq_cmd),
    .q_full  (q_full),
    .rd      (cmd_pop),
    .rd_cmd  (cmd),
    .q_empty (q_empty)
  );

  sha1md_core u_core (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .cmd         (cmd),
    .cmd_pop     (cmd_pop),
    .empty       (empty),
    .pop         (pop),
    .digest_word (digest_word),
    .word_number (word_number),
    .final_word  (final_word)
  );

endmodule
`default_nettype wire

// ===== rtl/core/sha1md_checker.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// sha1md_checker
// Port-level checks on the digest output sequence of the SHA-1 engine.
// ---------------------------------------------------------------------------
module sha1md_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        push,
  input wire logic        full,
  input wire logic [31:0] data_word,
  input wire logic [2:0]  byte_count,
  input wire logic        last,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic [31:0] digest_word,
  input wire logic [2:0]  word_number,
  input wire logic        final_word
);

  localparam logic [2:0] IDX_LAST = 3'(sha1md_pkg::DIGEST_WORDS - 1);

  logic unused_in;
  assign unused_in = push ^ full ^ (^data_word) ^ (^byte_count) ^ last;

  // after reset nothing waits on either side
  a_reset_clear: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("queue state not clear after reset");

  // after a pop of any but the last of the five digest words, the next one is shown
  a_words_contiguous: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && !final_word) |=> !empty)
    else $error("digest sequence broken");

  // word numbers count up by one
  a_word_order: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && !final_word) |=> (word_number == $past(word_number) + 3'd1))
    else $error("digest word out of order");

  // final flag marks exactly the last word
  a_final_flag: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (final_word == (word_number == IDX_LAST)))
    else $error("final_word mismatch");

  // a waiting result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(digest_word) && $stable(word_number)))
    else $error("waiting result changed");

endmodule

bind sha1_message_digest_top sha1md_checker u_checker (.*);
`default_nettype wire
